### hdl/mbdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbdr_pkg;

    localparam int RAW_W   = 20;
    localparam int IDX_W   = 5;
    localparam int OP_W    = 2;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BUTTONS_DEF = 20;

    localparam logic [CNT_W-1:0] PRESS_RST   = CNT_W'(20);
    localparam logic [CNT_W-1:0] RELEASE_RST = CNT_W'(20);
    localparam logic [CNT_W-1:0] REPEAT_RST  = CNT_W'(0);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE      = 2'd0,
        OP_TAKE_CHANGE = 2'd1,
        OP_TAKE_REPEAT = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS   = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_REPEAT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] press_ticks;
        logic [CNT_W-1:0] release_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic sample;
        logic clr_change;
        logic clr_repeat;
    } t_lane_ctl;

    typedef struct packed {
        logic level_now;
        logic level_after;
        logic event_hit;
        logic change_flag;
        logic repeat_flag;
    } t_lane_stat;

    typedef struct packed {
        logic             event_res;
        logic [RAW_W-1:0] pressed_buttons;
    } t_result;

endpackage

`default_nettype wire

### hdl/mbdr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface mbdr_in_if;
    logic                         valid;
    logic                         ready;
    logic [mbdr_pkg::OP_W-1:0]    operation;
    logic [mbdr_pkg::RAW_W-1:0]   raw_buttons;
    logic [mbdr_pkg::IDX_W-1:0]   button_index;

    modport source (output valid, output operation, output raw_buttons,
                    output button_index, input ready);
    modport sink   (input valid, input operation, input raw_buttons,
                    input button_index, output ready);
endinterface

interface mbdr_out_if;
    logic                         valid;
    logic                         ready;
    logic                         event_res;
    logic [mbdr_pkg::RAW_W-1:0]   pressed_buttons;

    modport source (output valid, output event_res, output pressed_buttons, input ready);
    modport sink   (input valid, input event_res, input pressed_buttons, output ready);
endinterface

interface mbdr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mbdr_pkg::CFG_IDX_W-1:0]   index;
    logic [mbdr_pkg::CNT_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/multi_button_debounce_repeat.sv
// A result is registered on o_out, or waits in the skid entry while o_out is held.
// Throughput: one transaction per cycle while i_in.ready is high; all buttons
// update in parallel lanes and one OR/select stage merges them into the result.
// A two-entry output buffer keeps i_in.ready high while one result waits.
// Reset (synchronous, active low): buttons released, flags clear, stability
// counters at 20, repeat counters at 0, configuration registers at their reset values.
`timescale 1ns / 1ps
`default_nettype none

module multi_button_debounce_repeat #(
    parameter int BUTTONS = mbdr_pkg::BUTTONS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mbdr_in_if.sink     i_in,
    mbdr_cfg_if.sink    i_cfg,
    mbdr_out_if.source  o_out
);

    mbdr_pkg::t_cfg        r_cfg;
    mbdr_pkg::t_lane_ctl   w_ctl  [BUTTONS];
    mbdr_pkg::t_lane_stat  w_stat [BUTTONS];
    mbdr_pkg::t_result     w_result;
    mbdr_pkg::t_result     r_out, n_out;
    mbdr_pkg::t_result     r_skid, n_skid;
    logic                  r_out_v, n_out_v;
    logic                  r_skid_v, n_skid_v;
    logic                  w_fire;
    logic                  w_out_fire;
    logic                  w_sample;
    logic [BUTTONS-1:0]    w_change_vec;
    logic [BUTTONS-1:0]    w_event_vec;
    logic [BUTTONS-1:0]    w_level_vec;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_ticks   <= mbdr_pkg::PRESS_RST;
            r_cfg.release_ticks <= mbdr_pkg::RELEASE_RST;
            r_cfg.repeat_ticks  <= mbdr_pkg::REPEAT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mbdr_pkg::CFG_PRESS:   r_cfg.press_ticks   <= i_cfg.data;
                mbdr_pkg::CFG_RELEASE: r_cfg.release_ticks <= i_cfg.data;
                mbdr_pkg::CFG_REPEAT:  r_cfg.repeat_ticks  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_skid_v;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_out_fire = r_out_v && o_out.ready;
    assign w_sample   = (i_in.operation == mbdr_pkg::OP_SAMPLE);

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        assign w_ctl[g].accept     = w_fire;
        assign w_ctl[g].sample     = w_sample;
        assign w_ctl[g].clr_change = (i_in.operation == mbdr_pkg::OP_TAKE_CHANGE)
                                     && (i_in.button_index == mbdr_pkg::IDX_W'(g));
        assign w_ctl[g].clr_repeat = (i_in.operation == mbdr_pkg::OP_TAKE_REPEAT)
                                     && (i_in.button_index == mbdr_pkg::IDX_W'(g));

        mbdr_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_raw   (i_in.raw_buttons[g]),
            .i_cfg   (r_cfg),
            .o_stat  (w_stat[g])
        );

        assign w_change_vec[g] = w_stat[g].change_flag;
        assign w_event_vec[g]  = w_stat[g].event_hit;
        assign w_level_vec[g]  = w_stat[g].level_now;
    end

    mbdr_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .i_stat   (w_stat),
        .i_op     (i_in.operation),
        .i_idx    (i_in.button_index),
        .o_result (w_result)
    );

    // output register plus skid entry
    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (w_out_fire) begin
            n_out_v = 1'b0;
        end
        if (r_skid_v && w_out_fire) begin
            n_out    = r_skid;
            n_out_v  = 1'b1;
            n_skid_v = 1'b0;
        end
        if (w_fire) begin
            if (!n_out_v) begin
                n_out   = w_result;
                n_out_v = 1'b1;
            end else begin
                n_skid   = w_result;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid           = r_out_v;
    assign o_out.event_res       = r_out.event_res;
    assign o_out.pressed_buttons = r_out.pressed_buttons;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a result while the output register is empty");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_in.operation == mbdr_pkg::OP_TAKE_CHANGE
            && i_in.button_index < mbdr_pkg::IDX_W'(BUTTONS)
        |=> ((w_change_vec >> $past(i_in.button_index)) & BUTTONS'(1)) == '0)
        else $error("change flag still set after it was taken");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_sample && !(|w_event_vec) |=> $stable(w_level_vec))
        else $error("debounced level moved on a tick without an event");

endmodule

`default_nettype wire

### hdl/mbdr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mbdr_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mbdr_pkg::t_lane_ctl   i_ctl,
    input  wire logic                  i_raw,
    input  wire mbdr_pkg::t_cfg        i_cfg,
    output mbdr_pkg::t_lane_stat       o_stat
);

    logic                        r_level, n_level;
    logic                        r_change, n_change;
    logic                        r_repeat, n_repeat;
    logic [mbdr_pkg::CNT_W-1:0]  r_stable, n_stable;
    logic [mbdr_pkg::CNT_W-1:0]  r_rpt_cnt, n_rpt_cnt;
    logic [mbdr_pkg::CNT_W-1:0]  w_stable_dec;
    logic [mbdr_pkg::CNT_W-1:0]  w_rpt_dec;
    logic                        w_event;

    assign w_stable_dec = r_stable - mbdr_pkg::CNT_W'(1);
    assign w_rpt_dec    = r_rpt_cnt - mbdr_pkg::CNT_W'(1);

    always_comb begin
        n_level   = r_level;
        n_change  = r_change;
        n_repeat  = r_repeat;
        n_stable  = r_stable;
        n_rpt_cnt = r_rpt_cnt;
        w_event   = 1'b0;
        if (i_ctl.sample) begin
            if (i_raw == r_level) begin
                if (r_level) begin
                    n_stable = i_cfg.release_ticks;
                    if (w_rpt_dec == '0 && i_cfg.repeat_ticks != '0) begin
                        n_rpt_cnt = i_cfg.repeat_ticks;
                        n_repeat  = 1'b1;
                        w_event   = 1'b1;
                    end else begin
                        // wraps freely when repeat is disabled
                        n_rpt_cnt = w_rpt_dec;
                    end
                end else begin
                    n_stable = i_cfg.press_ticks;
                end
            end else if (w_stable_dec == '0) begin
                n_level   = i_raw;
                n_change  = 1'b1;
                n_rpt_cnt = i_cfg.repeat_ticks;
                n_repeat  = 1'b0;
                w_event   = 1'b1;
                n_stable  = i_raw ? i_cfg.release_ticks : i_cfg.press_ticks;
            end else begin
                n_stable = w_stable_dec;
            end
        end
        if (i_ctl.clr_change) begin
            n_change = 1'b0;
        end
        if (i_ctl.clr_repeat) begin
            n_repeat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_change  <= 1'b0;
            r_repeat  <= 1'b0;
            r_stable  <= mbdr_pkg::PRESS_RST;
            r_rpt_cnt <= mbdr_pkg::REPEAT_RST;
        end else if (i_ctl.accept) begin
            r_level   <= n_level;
            r_change  <= n_change;
            r_repeat  <= n_repeat;
            r_stable  <= n_stable;
            r_rpt_cnt <= n_rpt_cnt;
        end
    end

    assign o_stat.level_now   = r_level;
    assign o_stat.level_after = n_level;
    assign o_stat.event_hit   = w_event;
    assign o_stat.change_flag = r_change;
    assign o_stat.repeat_flag = r_repeat;

endmodule

`default_nettype wire

### hdl/mbdr_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module mbdr_merge #(
    parameter int BUTTONS = mbdr_pkg::BUTTONS_DEF
) (
    input  wire mbdr_pkg::t_lane_stat       i_stat [BUTTONS],
    input  wire logic [mbdr_pkg::OP_W-1:0]  i_op,
    input  wire logic [mbdr_pkg::IDX_W-1:0] i_idx,
    output mbdr_pkg::t_result               o_result
);

    logic w_any;
    logic w_chg_sel;
    logic w_rpt_sel;
    logic [mbdr_pkg::RAW_W-1:0] w_levels;

    always_comb begin
        w_any     = 1'b0;
        w_chg_sel = 1'b0;
        w_rpt_sel = 1'b0;
        w_levels  = '0;
        for (int n = 0; n < BUTTONS; n++) begin
            w_any       = w_any | i_stat[n].event_hit;
            w_levels[n] = i_stat[n].level_after;
            // out-of-range index matches no lane and reads as zero
            if (i_idx == mbdr_pkg::IDX_W'(n)) begin
                w_chg_sel = i_stat[n].change_flag;
                w_rpt_sel = i_stat[n].repeat_flag;
            end
        end
    end

    always_comb begin
        o_result.pressed_buttons = w_levels;
        unique case (i_op)
            mbdr_pkg::OP_SAMPLE:      o_result.event_res = w_any;
            mbdr_pkg::OP_TAKE_CHANGE: o_result.event_res = w_chg_sel;
            mbdr_pkg::OP_TAKE_REPEAT: o_result.event_res = w_rpt_sel;
            default:                  o_result.event_res = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import mbdr_pkg::*;

    localparam int BUTTONS = BUTTONS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam int HOLD_CYCLES = 60;
    localparam int FILL_ITEMS = 40;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [OP_W-1:0]  op;
        logic [RAW_W-1:0] raw;
        logic [IDX_W-1:0] idx;
        bit               known;
        t_result          res;
        t_cfg_idx         reg_idx;
        logic [CNT_W-1:0] reg_data;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    mbdr_in_if  in_if ();
    mbdr_cfg_if cfg_if ();
    mbdr_out_if out_if ();

    multi_button_debounce_repeat dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Debouncer state as seen by the predictor
    t_cfg               ticks_q;
    logic [BUTTONS-1:0] level_q;
    logic [BUTTONS-1:0] change_q;
    logic [BUTTONS-1:0] repeat_q;
    logic [CNT_W-1:0]   stable_cnt_q [BUTTONS];
    logic [CNT_W-1:0]   repeat_cnt_q [BUTTONS];

    t_result pending_results [$];
    t_row    plan [$];
    t_result want;
    int      mismatches = 0;

    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int rx_cycle = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_result debounce_step(input logic [OP_W-1:0] op,
                                              input logic [RAW_W-1:0] raw,
                                              input logic [IDX_W-1:0] idx);
        t_result r;
        logic    hit;
        hit = 1'b0;
        if (op == OP_SAMPLE) begin
            for (int n = 0; n < BUTTONS; n++) begin
                if (raw[n] == level_q[n]) begin
                    if (raw[n]) begin
                        stable_cnt_q[n] = ticks_q.release_ticks;
                        repeat_cnt_q[n] = repeat_cnt_q[n] - 1'b1;
                        if (repeat_cnt_q[n] == '0 && ticks_q.repeat_ticks != '0) begin
                            repeat_cnt_q[n] = ticks_q.repeat_ticks;
                            repeat_q[n] = 1'b1;
                            hit = 1'b1;
                        end
                    end else begin
                        stable_cnt_q[n] = ticks_q.press_ticks;
                    end
                end else begin
                    stable_cnt_q[n] = stable_cnt_q[n] - 1'b1;
                    if (stable_cnt_q[n] == '0) begin
                        level_q[n] = raw[n];
                        change_q[n] = 1'b1;
                        repeat_cnt_q[n] = ticks_q.repeat_ticks;
                        repeat_q[n] = 1'b0;
                        hit = 1'b1;
                        stable_cnt_q[n] = raw[n] ? ticks_q.release_ticks
                                                 : ticks_q.press_ticks;
                    end
                end
            end
        end else if ((op == OP_TAKE_CHANGE || op == OP_TAKE_REPEAT) && idx < BUTTONS) begin
            if (op == OP_TAKE_CHANGE) begin
                hit = change_q[idx];
                change_q[idx] = 1'b0;
            end else begin
                hit = repeat_q[idx];
                repeat_q[idx] = 1'b0;
            end
        end
        r.event_res = hit;
        r.pressed_buttons = RAW_W'(level_q);
        return r;
    endfunction

    function automatic t_row item_row(input logic [OP_W-1:0] op,
                                      input logic [RAW_W-1:0] raw,
                                      input logic [IDX_W-1:0] idx,
                                      input bit known,
                                      input logic ev,
                                      input logic [RAW_W-1:0] pressed);
        t_row row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.raw = raw;
        row.idx = idx;
        row.known = known;
        row.res.event_res = ev;
        row.res.pressed_buttons = pressed;
        row.reg_idx = CFG_PRESS;
        row.reg_data = '0;
        return row;
    endfunction

    function automatic t_row reg_row(input t_cfg_idx ri, input logic [CNT_W-1:0] d);
        t_row row;
        row = item_row(OP_SAMPLE, '0, '0, PREDICTED, 1'b0, '0);
        row.kind = ROW_REG;
        row.reg_idx = ri;
        row.reg_data = d;
        return row;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                             input logic [IDX_W-1:0] idx, input bit known,
                             input t_result typed);
        t_result predicted;
        in_if.valid <= 1'b1;
        in_if.operation <= op;
        in_if.raw_buttons <= raw;
        in_if.button_index <= idx;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = debounce_step(op, raw, idx);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx ri, input logic [CNT_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= ri;
        cfg_if.data <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (ri)
            CFG_PRESS:   ticks_q.press_ticks = d;
            CFG_RELEASE: ticks_q.release_ticks = d;
            CFG_REPEAT:  ticks_q.repeat_ticks = d;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Runs of steady levels with some bounce, mixed with flag takes
    task automatic run_phase(input logic [CNT_W-1:0] pr, input logic [CNT_W-1:0] rl,
                             input logic [CNT_W-1:0] rp, input int count,
                             input bit with_hold);
        logic [RAW_W-1:0] target;
        logic [RAW_W-1:0] raw;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        int               run_left;
        int               span;
        int               burst_left;
        int               fill_left;
        int unsigned      pick;
        drain_results();
        write_reg(CFG_PRESS, pr);
        write_reg(CFG_RELEASE, rl);
        write_reg(CFG_REPEAT, rp);
        span = ((pr > rl) ? int'(pr) : int'(rl)) + int'(rp) + 4;
        if (span > 48) span = 48;
        target = RAW_W'($urandom);
        run_left = 0;
        burst_left = 0;
        fill_left = 0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                case ($urandom_range(0, 3))
                    0: target = target ^ (RAW_W'(1) << $urandom_range(0, RAW_W - 1));
                    1: target = RAW_W'($urandom);
                    2: target = target ^ (RAW_W'($urandom) & RAW_W'($urandom));
                    default: target = $urandom_range(0, 1) ? '1 : '0;
                endcase
                run_left = $urandom_range(1, span);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(BUTTONS, 31))
                                              : IDX_W'($urandom_range(0, BUTTONS - 1));
            if (pick < 68) begin
                op = OP_SAMPLE;
                raw = (pick < 8) ? target ^ RAW_W'($urandom) : target;
            end else if (pick < 94) begin
                op = $urandom_range(0, 1) ? OP_TAKE_CHANGE : OP_TAKE_REPEAT;
                raw = RAW_W'($urandom);
            end else begin
                op = OP_UNUSED;
                raw = RAW_W'($urandom);
            end
            send_item(op, raw, idx, PREDICTED, '0);
            if (with_hold && k == 60) begin
                // receiver goes quiet while we keep pushing
                hold_requests++;
                fill_left = FILL_ITEMS;
            end
            if (k == count / 2) begin
                drain_results();
            end else if (fill_left > 0) begin
                fill_left--;
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                idle_cycles($urandom_range(0, 6));
            end
        end
    endtask

    // Receiver: ready pattern changes at random intervals; long hold on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    2: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= rx_cycle[1];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, event_res %0b pressed_buttons %05h",
                         $time, out_if.event_res, out_if.pressed_buttons);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.event_res !== want.event_res) begin
                    $display("%0t: event_res expected %0b actual %0b",
                             $time, want.event_res, out_if.event_res);
                    mismatches++;
                end
                if (out_if.pressed_buttons !== want.pressed_buttons) begin
                    $display("%0t: pressed_buttons expected %05h actual %05h",
                             $time, want.pressed_buttons, out_if.pressed_buttons);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] rnd_press;
        logic [CNT_W-1:0] rnd_release;
        logic [CNT_W-1:0] rnd_repeat;

        ticks_q.press_ticks = PRESS_RST;
        ticks_q.release_ticks = RELEASE_RST;
        ticks_q.repeat_ticks = REPEAT_RST;
        level_q = '0;
        change_q = '0;
        repeat_q = '0;
        for (int n = 0; n < BUTTONS; n++) begin
            stable_cnt_q[n] = PRESS_RST;
            repeat_cnt_q[n] = REPEAT_RST;
        end

        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.operation <= OP_SAMPLE;
        in_if.raw_buttons <= '0;
        in_if.button_index <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_PRESS;
        cfg_if.data <= '0;

        // after reset: nothing pressed, no flags, counters at reset values
        plan.push_back(item_row(OP_TAKE_CHANGE, 20'h00000, 5'd0, TYPED, 1'b0, 20'h00000));
        plan.push_back(item_row(OP_TAKE_REPEAT, 20'hFFFFF, 5'd19, TYPED, 1'b0, 20'h00000));
        plan.push_back(item_row(OP_TAKE_CHANGE, 20'h00000, 5'd31, TYPED, 1'b0, 20'h00000));
        plan.push_back(item_row(OP_UNUSED, 20'hFFFFF, 5'd31, TYPED, 1'b0, 20'h00000));
        plan.push_back(item_row(OP_SAMPLE, 20'h00000, 5'd0, TYPED, 1'b0, 20'h00000));
        plan.push_back(item_row(OP_SAMPLE, 20'hFFFFF, 5'd0, TYPED, 1'b0, 20'h00000));
        // shortest press debounce, repeat every tick
        plan.push_back(reg_row(CFG_PRESS, 16'd1));
        plan.push_back(reg_row(CFG_RELEASE, 16'd2));
        plan.push_back(reg_row(CFG_REPEAT, 16'd1));
        plan.push_back(item_row(OP_SAMPLE, 20'h00000, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_SAMPLE, 20'hFFFFF, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_SAMPLE, 20'hFFFFF, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_TAKE_CHANGE, 20'h00000, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_TAKE_REPEAT, 20'h00000, 5'd19, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_TAKE_REPEAT, 20'h00000, 5'd20, TYPED, 1'b0, 20'hFFFFF));
        // bounce during release, then a clean release
        plan.push_back(item_row(OP_SAMPLE, 20'h00000, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_SAMPLE, 20'hFFFFF, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_SAMPLE, 20'h00000, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_SAMPLE, 20'h00000, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_TAKE_CHANGE, 20'h00000, 5'd5, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_UNUSED, 20'hAAAAA, 5'd21, TYPED, 1'b0, 20'h00000));
        // repeat disabled: counter wraps while held, no flag
        plan.push_back(reg_row(CFG_REPEAT, 16'd0));
        plan.push_back(item_row(OP_SAMPLE, 20'h5A5A5, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_SAMPLE, 20'h5A5A5, 5'd0, PREDICTED, 1'b0, '0));
        plan.push_back(item_row(OP_TAKE_REPEAT, 20'h00000, 5'd2, PREDICTED, 1'b0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                drain_results();
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            end else begin
                send_item(plan[r].op, plan[r].raw, plan[r].idx, plan[r].known, plan[r].res);
                idle_cycles($urandom_range(0, 2));
            end
        end

        run_phase(16'd1, 16'd1, 16'd1, 250, 1'b1);
        run_phase(16'd3, 16'd2, 16'd4, 250, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 1'b0);
        run_phase(16'd2, 16'd5, 16'd0, 250, 1'b0);
        run_phase(16'd1, 16'hFFFF, 16'd3, 150, 1'b1);
        rnd_press = CNT_W'($urandom_range(1, 6));
        rnd_release = CNT_W'($urandom_range(1, 6));
        rnd_repeat = CNT_W'($urandom_range(0, 8));
        run_phase(rnd_press, rnd_release, rnd_repeat, 310, 1'b0);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
